@@ rtl/dphq_pkg.sv @@
// Shared types and constants for the deadline priority heap queue.
package dphq_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned COUNT_OUT_W = 7;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned TIME_W     = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_EDF  = 1'b1
  } policy_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] arrival;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_PLACE,
    S_HEAD_RD,
    S_OUT
  } state_e;

endpackage

@@ rtl/dphq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dphq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                  wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/dphq_rank.sv @@
// Priority compare: true when entry a must sit above entry b under the policy.
module dphq_rank (
  input  dphq_pkg::policy_e policy_i,
  input  dphq_pkg::entry_t  a_i,
  input  dphq_pkg::entry_t  b_i,
  output logic              before_o
);

  logic dl_ne;
  logic dl_lt;
  logic ar_lt;

  assign dl_ne = (a_i.deadline != b_i.deadline);
  assign dl_lt = (a_i.deadline < b_i.deadline);
  assign ar_lt = (a_i.arrival < b_i.arrival);

  always_comb begin
    before_o = ar_lt;
    if (policy_i == dphq_pkg::POLICY_EDF && dl_ne) begin
      before_o = dl_lt;
    end
  end

endmodule

@@ rtl/deadline_priority_heap_queue_unit.sv @@
// Top level of the deadline priority heap queue: sequencer, heap RAM and compare unit.
//
//   channel   signals                                         beat taken when
//   command   start, kind_i, requester_id_i, deadline_i,      start && !busy
//             arrival_time_i
//   result    done_o, head_valid_o, head_id_o, head_deadline_o, done_o high (one cycle)
//             head_arrival_o, entry_count_o, push_rejected_o
//   config    cfg_we_i, cfg_wdata_i                           cfg_we_i high
//
// One command at a time: busy is high from the cycle after acceptance until the strobe.
// Peek, rejected push and empty pop go straight to the head read; a push into an empty
// queue is placed at once; other pushes compare parent by parent; an emptying pop
// skips the descent; other pops sift down, comparing any children at each level.
// Reset clears the sequencer, count and policy; slots at or above the count go unused.
// The receiver cannot stall: each result beat lasts exactly one cycle.
module deadline_priority_heap_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [dphq_pkg::KIND_W-1:0]         kind_i,
  input  logic [dphq_pkg::ID_W-1:0]           requester_id_i,
  input  logic [dphq_pkg::TIME_W-1:0]         deadline_i,
  input  logic [dphq_pkg::TIME_W-1:0]         arrival_time_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  output logic                                done_o,
  output logic                                head_valid_o,
  output logic [dphq_pkg::ID_W-1:0]           head_id_o,
  output logic [dphq_pkg::TIME_W-1:0]         head_deadline_o,
  output logic [dphq_pkg::TIME_W-1:0]         head_arrival_o,
  output logic [dphq_pkg::COUNT_OUT_W-1:0]    entry_count_o,
  output logic                                push_rejected_o
);

  localparam int unsigned IdxW = dphq_pkg::IDX_W;
  localparam int unsigned CntW = dphq_pkg::CNT_W;
  localparam int unsigned ChW  = IdxW + 2;

  dphq_pkg::state_e  state_q, state_d;
  dphq_pkg::policy_e policy_q;
  logic [CntW-1:0]   count_q;
  logic [IdxW-1:0]   pos_q;
  dphq_pkg::entry_t  cur_q;
  dphq_pkg::entry_t  lc_q;
  logic              lc_win_q;
  logic              rej_q;

  logic              done_q;
  logic              head_valid_q;
  dphq_pkg::entry_t  head_q;

  // RAM port
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  dphq_pkg::entry_t  ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  dphq_pkg::entry_t  ram_rdata;

  // compare unit
  dphq_pkg::entry_t  cmp_a;
  dphq_pkg::entry_t  cmp_b;
  logic              cmp_before;

  logic [ChW-1:0]    lc_idx;
  logic [ChW-1:0]    rc_idx;
  logic [ChW-1:0]    count_ext;
  logic              lc_in;
  logic              rc_in;
  logic [IdxW-1:0]   parent_idx;
  logic              rc_win;
  logic              accept;
  logic              is_full;

  assign accept     = start && !busy;
  assign is_full    = (count_q == CntW'(dphq_pkg::QUEUE_DEPTH));
  assign lc_idx     = {1'b0, pos_q, 1'b1};
  assign rc_idx     = ChW'({1'b0, pos_q, 1'b1}) + ChW'(1);
  assign count_ext  = ChW'(count_q);
  assign lc_in      = (lc_idx < count_ext);
  assign rc_in      = (rc_idx < count_ext);
  assign parent_idx = (pos_q - IdxW'(1)) >> 1;
  assign rc_win     = rc_in && cmp_before;

  dphq_ram #(
    .WIDTH(dphq_pkg::ENTRY_W),
    .DEPTH(dphq_pkg::QUEUE_DEPTH)
  ) u_heap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  dphq_rank u_rank (
    .policy_i(policy_q),
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .before_o(cmp_before)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dphq_pkg::S_IDLE: begin
        if (accept) begin
          case (dphq_pkg::kind_e'(kind_i))
            dphq_pkg::KIND_PUSH: begin
              if (is_full) begin
                state_d = dphq_pkg::S_HEAD_RD;
              end else if (count_q == '0) begin
                state_d = dphq_pkg::S_PLACE;
              end else begin
                state_d = dphq_pkg::S_UP_RD;
              end
            end
            dphq_pkg::KIND_POP: begin
              state_d = (count_q == '0) ? dphq_pkg::S_HEAD_RD : dphq_pkg::S_POP_LD;
            end
            default: state_d = dphq_pkg::S_HEAD_RD;
          endcase
        end
      end
      dphq_pkg::S_POP_LD: begin
        state_d = (count_q == '0) ? dphq_pkg::S_HEAD_RD : dphq_pkg::S_DN_RDL;
      end
      dphq_pkg::S_UP_RD:  state_d = dphq_pkg::S_UP_CMP;
      dphq_pkg::S_UP_CMP: begin
        if (cmp_before && parent_idx != '0) begin
          state_d = dphq_pkg::S_UP_RD;
        end else begin
          state_d = dphq_pkg::S_PLACE;
        end
      end
      dphq_pkg::S_DN_RDL: state_d = lc_in ? dphq_pkg::S_DN_RDR : dphq_pkg::S_PLACE;
      dphq_pkg::S_DN_RDR: state_d = dphq_pkg::S_DN_CMP;
      dphq_pkg::S_DN_CMP: begin
        state_d = (rc_win || lc_win_q) ? dphq_pkg::S_DN_RDL : dphq_pkg::S_PLACE;
      end
      dphq_pkg::S_PLACE:   state_d = dphq_pkg::S_HEAD_RD;
      dphq_pkg::S_HEAD_RD: state_d = dphq_pkg::S_OUT;
      dphq_pkg::S_OUT:     state_d = dphq_pkg::S_IDLE;
      default:             state_d = dphq_pkg::S_IDLE;
    endcase
  end

  // RAM and compare unit control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = cur_q;
    ram_raddr = '0;
    cmp_a     = cur_q;
    cmp_b     = ram_rdata;
    case (state_q)
      dphq_pkg::S_IDLE: begin
        // last slot, used only when a pop is taken
        ram_raddr = IdxW'(count_q - CntW'(1));
      end
      dphq_pkg::S_UP_RD: ram_raddr = parent_idx;
      dphq_pkg::S_UP_CMP: begin
        cmp_a     = cur_q;
        cmp_b     = ram_rdata;
        ram_we    = cmp_before;
        ram_wdata = ram_rdata;
      end
      dphq_pkg::S_DN_RDL: ram_raddr = IdxW'(lc_idx);
      dphq_pkg::S_DN_RDR: begin
        ram_raddr = IdxW'(rc_idx);
        cmp_a     = ram_rdata;
        cmp_b     = cur_q;
      end
      dphq_pkg::S_DN_CMP: begin
        cmp_a     = ram_rdata;
        cmp_b     = lc_win_q ? lc_q : cur_q;
        ram_we    = rc_win || lc_win_q;
        ram_wdata = rc_win ? ram_rdata : lc_q;
      end
      dphq_pkg::S_PLACE: ram_we = 1'b1;
      default: ram_raddr = '0;
    endcase
  end

  assign busy = (state_q != dphq_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dphq_pkg::S_IDLE;
      policy_q     <= dphq_pkg::POLICY_FIFO;
      count_q      <= '0;
      done_q       <= 1'b0;
      rej_q        <= 1'b0;
      head_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == dphq_pkg::S_OUT);
      if (cfg_we_i) begin
        policy_q <= dphq_pkg::policy_e'(cfg_wdata_i);
      end
      if (accept) begin
        rej_q <= 1'b0;
        if (dphq_pkg::kind_e'(kind_i) == dphq_pkg::KIND_PUSH) begin
          if (is_full) begin
            rej_q <= 1'b1;
          end else begin
            count_q <= count_q + CntW'(1);
          end
        end else if (dphq_pkg::kind_e'(kind_i) == dphq_pkg::KIND_POP && count_q != '0) begin
          count_q <= count_q - CntW'(1);
        end
      end
      if (state_q == dphq_pkg::S_OUT) begin
        head_valid_q <= (count_q != '0);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      dphq_pkg::S_IDLE: begin
        if (accept) begin
          cur_q.id       <= requester_id_i;
          cur_q.deadline <= deadline_i;
          cur_q.arrival  <= arrival_time_i;
          pos_q          <= IdxW'(count_q);
        end
      end
      dphq_pkg::S_POP_LD: begin
        cur_q <= ram_rdata;
        pos_q <= '0;
      end
      dphq_pkg::S_UP_CMP: begin
        if (cmp_before) begin
          pos_q <= parent_idx;
        end
      end
      dphq_pkg::S_DN_RDR: begin
        lc_q     <= ram_rdata;
        lc_win_q <= cmp_before;
      end
      dphq_pkg::S_DN_CMP: begin
        if (rc_win) begin
          pos_q <= IdxW'(rc_idx);
        end else if (lc_win_q) begin
          pos_q <= IdxW'(lc_idx);
        end
      end
      dphq_pkg::S_OUT: begin
        head_q <= (count_q != '0) ? ram_rdata : '0;
      end
      default: begin
      end
    endcase
  end

  assign done_o          = done_q;
  assign head_valid_o    = head_valid_q;
  assign head_id_o       = head_q.id;
  assign head_deadline_o = head_q.deadline;
  assign head_arrival_o  = head_q.arrival;
  assign entry_count_o   = dphq_pkg::COUNT_OUT_W'(count_q);
  assign push_rejected_o = rej_q;

endmodule
